// ===== hdl/mtg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mtg_pkg;

  // Store geometry
  localparam int unsigned STORE_WORDS = 624;
  localparam int unsigned ADDR_W      = 10;
  localparam int unsigned WORD_W      = 32;

  localparam logic [ADDR_W-1:0] LAST_ADDR      = 10'd623;
  localparam logic [ADDR_W-1:0] TWIST_SHIFT    = 10'd397;
  localparam logic [ADDR_W-1:0] INDEX_TWIST    = 10'd624;
  localparam logic [ADDR_W-1:0] INDEX_UNSEEDED = 10'd625;

  // Recurrence and tempering constants
  localparam logic [WORD_W-1:0] DEFAULT_SEED = 32'd5489;
  localparam logic [WORD_W-1:0] INIT_MULT    = 32'd1812433253;
  localparam logic [WORD_W-1:0] MATRIX_A     = 32'h9908_b0df;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hefc6_0000;

  // Operation codes
  localparam logic OP_SEED     = 1'b0;
  localparam logic OP_GENERATE = 1'b1;

  // Sequencer states
  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SEED_MUL = 8'b0000_0010,
    ST_SEED_ADD = 8'b0000_0100,
    ST_TW_P0    = 8'b0000_1000,
    ST_TW_P1    = 8'b0001_0000,
    ST_TW_RUN   = 8'b0010_0000,
    ST_GEN_RD   = 8'b0100_0000,
    ST_GEN_OUT  = 8'b1000_0000
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/mtg_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mtg_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] seed;

  modport source (output valid, output op, output seed, input ready);
  modport sink   (input valid, input op, input seed, output ready);
endinterface

`default_nettype wire

// ===== hdl/mtg_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface mtg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

`default_nettype wire

// ===== hdl/mtg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtg_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_a_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_a_addr,
  output logic      [WIDTH-1:0]         rd_a_data,
  input  wire logic                     rd_b_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_b_addr,
  output logic      [WIDTH-1:0]         rd_b_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered reads; data holds while the port is idle
  always_ff @(posedge clk) begin
    if (rd_a_en) begin
      rd_a_data <= mem[rd_a_addr];
    end
    if (rd_b_en) begin
      rd_b_data <= mem[rd_b_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/mtg_twist.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtg_twist (
  input  wire logic        upper_bit,
  input  wire logic [31:0] next_word,
  input  wire logic [31:0] far_word,
  output logic      [31:0] twisted
);

  logic [31:0] y;

  // Join the top bit of the current word with the low bits of the next one
  assign y = {upper_bit, next_word[30:0]};

  // Shift, fold in the twist matrix on an odd value
  assign twisted = far_word ^ {1'b0, y[31:1]} ^ (y[0] ? mtg_pkg::MATRIX_A : 32'd0);

endmodule

`default_nettype wire

// ===== hdl/mtg_temper.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mtg_temper (
  input  wire logic [31:0] raw,
  output logic      [31:0] tempered
);

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] t3;

  // Four shift-and-XOR steps, the middle two masked
  assign t1       = raw ^ (raw >> 11);
  assign t2       = t1 ^ ((t1 << 7) & mtg_pkg::TEMPER_B);
  assign t3       = t2 ^ ((t2 << 15) & mtg_pkg::TEMPER_C);
  assign tempered = t3 ^ (t3 >> 18);

endmodule

`default_nettype wire

// ===== hdl/mersenne_twister_generator_top.sv =====
// Generate: GEN_RD reads the word, then GEN_OUT tempers it into the result register, waiting
// while the output is stalled. Every 624th word first twists the store, one store word per
// cycle through the two-read, one-write state RAM. Seed: a multiply, then an add, per word.
// The first generate after reset also seeds with 5489 before its twist.
// Reset (rst, synchronous) clears the sequencer and output valid and sets the index to 625;
// the state RAM is not cleared, since no word is read before a seed writes it.
`timescale 1ns / 1ps
`default_nettype none

module mersenne_twister_generator_top (
  input wire logic  clk,
  input wire logic  rst,
  mtg_in_if.sink    in,
  mtg_out_if.source out
);

  localparam int unsigned AW = mtg_pkg::ADDR_W;

  mtg_pkg::state_t state;
  mtg_pkg::state_t state_next;

  logic [AW-1:0] read_index;
  logic [AW-1:0] step;
  logic [AW-1:0] a_ptr;
  logic [AW-1:0] b_ptr;
  logic          gen_pending;
  logic          upper_bit;
  logic [31:0]   prev_word;
  logic [31:0]   product;
  logic [31:0]   out_word;
  logic          out_valid;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [31:0]   wr_data;
  logic          rd_a_en;
  logic [AW-1:0] rd_a_addr;
  logic [31:0]   rd_a_data;
  logic          rd_b_en;
  logic [AW-1:0] rd_b_addr;
  logic [31:0]   rd_b_data;

  logic [31:0]   twisted;
  logic [31:0]   tempered;
  logic [31:0]   seed_word;
  logic [31:0]   start_seed;
  logic [AW-1:0] a_ptr_next;
  logic [AW-1:0] b_ptr_next;
  logic          in_xfer;
  logic          out_free;

  assign in_xfer  = in.valid && in.ready;
  assign out_free = !out_valid || out.ready;
  assign in.ready = (state == mtg_pkg::ST_IDLE);

  assign out.valid       = out_valid;
  assign out.random_word = out_word;

  assign seed_word  = product + {{(32-AW){1'b0}}, step};
  assign start_seed = (in.op == mtg_pkg::OP_SEED) ? in.seed : mtg_pkg::DEFAULT_SEED;
  assign a_ptr_next = (a_ptr == mtg_pkg::LAST_ADDR) ? '0 : a_ptr + 1'b1;
  assign b_ptr_next = (b_ptr == mtg_pkg::LAST_ADDR) ? '0 : b_ptr + 1'b1;

  mtg_ram #(
    .WIDTH (32),
    .DEPTH (mtg_pkg::STORE_WORDS)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_en   (rd_a_en),
    .rd_a_addr (rd_a_addr),
    .rd_a_data (rd_a_data),
    .rd_b_en   (rd_b_en),
    .rd_b_addr (rd_b_addr),
    .rd_b_data (rd_b_data)
  );

  mtg_twist u_twist (
    .upper_bit (upper_bit),
    .next_word (rd_a_data),
    .far_word  (rd_b_data),
    .twisted   (twisted)
  );

  mtg_temper u_temper (
    .raw      (rd_a_data),
    .tempered (tempered)
  );

  // Next state and RAM port control
  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = step;
    wr_data    = twisted;
    rd_a_en    = 1'b0;
    rd_a_addr  = a_ptr_next;
    rd_b_en    = 1'b0;
    rd_b_addr  = b_ptr_next;
    unique case (state)
      mtg_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (in.op == mtg_pkg::OP_SEED || read_index == mtg_pkg::INDEX_UNSEEDED) begin
            wr_en      = 1'b1;
            wr_addr    = '0;
            wr_data    = start_seed;
            state_next = mtg_pkg::ST_SEED_MUL;
          end else if (read_index == mtg_pkg::INDEX_TWIST) begin
            state_next = mtg_pkg::ST_TW_P0;
          end else begin
            state_next = mtg_pkg::ST_GEN_RD;
          end
        end
      end
      mtg_pkg::ST_SEED_MUL: begin
        state_next = mtg_pkg::ST_SEED_ADD;
      end
      mtg_pkg::ST_SEED_ADD: begin
        wr_en   = 1'b1;
        wr_data = seed_word;
        if (step == mtg_pkg::LAST_ADDR) begin
          state_next = gen_pending ? mtg_pkg::ST_TW_P0 : mtg_pkg::ST_IDLE;
        end else begin
          state_next = mtg_pkg::ST_SEED_MUL;
        end
      end
      mtg_pkg::ST_TW_P0: begin
        rd_a_en    = 1'b1;
        rd_a_addr  = '0;
        state_next = mtg_pkg::ST_TW_P1;
      end
      mtg_pkg::ST_TW_P1: begin
        rd_a_en    = 1'b1;
        rd_a_addr  = AW'(1);
        rd_b_en    = 1'b1;
        rd_b_addr  = mtg_pkg::TWIST_SHIFT;
        state_next = mtg_pkg::ST_TW_RUN;
      end
      mtg_pkg::ST_TW_RUN: begin
        wr_en = 1'b1;
        if (step == mtg_pkg::LAST_ADDR) begin
          state_next = mtg_pkg::ST_GEN_RD;
        end else begin
          rd_a_en = 1'b1;
          rd_b_en = 1'b1;
        end
      end
      mtg_pkg::ST_GEN_RD: begin
        rd_a_en    = 1'b1;
        rd_a_addr  = read_index;
        state_next = mtg_pkg::ST_GEN_OUT;
      end
      mtg_pkg::ST_GEN_OUT: begin
        if (out_free) begin
          state_next = mtg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = mtg_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mtg_pkg::ST_IDLE;
      read_index  <= mtg_pkg::INDEX_UNSEEDED;
      gen_pending <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == mtg_pkg::ST_IDLE && in_xfer) begin
        gen_pending <= (in.op == mtg_pkg::OP_GENERATE);
      end
      if (state == mtg_pkg::ST_SEED_ADD && step == mtg_pkg::LAST_ADDR) begin
        read_index <= mtg_pkg::INDEX_TWIST;
      end else if (state == mtg_pkg::ST_TW_RUN && step == mtg_pkg::LAST_ADDR) begin
        read_index <= '0;
      end else if (state == mtg_pkg::ST_GEN_OUT && out_free) begin
        read_index <= read_index + 1'b1;
      end
      // Load the result register, or drop it after its transfer
      if (state == mtg_pkg::ST_GEN_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      mtg_pkg::ST_IDLE: begin
        prev_word <= start_seed;
        step      <= AW'(1);
      end
      mtg_pkg::ST_SEED_MUL: begin
        product <= mtg_pkg::INIT_MULT * (prev_word ^ (prev_word >> 30));
      end
      mtg_pkg::ST_SEED_ADD: begin
        prev_word <= seed_word;
        step      <= step + 1'b1;
      end
      mtg_pkg::ST_TW_P0: begin
        step <= '0;
      end
      mtg_pkg::ST_TW_P1: begin
        upper_bit <= rd_a_data[31];
        a_ptr     <= AW'(1);
        b_ptr     <= mtg_pkg::TWIST_SHIFT;
      end
      mtg_pkg::ST_TW_RUN: begin
        upper_bit <= rd_a_data[31];
        a_ptr     <= a_ptr_next;
        b_ptr     <= b_ptr_next;
        step      <= step + 1'b1;
      end
      mtg_pkg::ST_GEN_RD: begin
      end
      mtg_pkg::ST_GEN_OUT: begin
        if (out_free) begin
          out_word <= tempered;
        end
      end
      default: begin
      end
    endcase
  end

  // The index never leaves 0 to 625
  assert property (@(posedge clk) disable iff (rst)
    read_index <= mtg_pkg::INDEX_UNSEEDED)
    else $error("read index out of range");

  // A twist write never lands on an entry being read in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    wr_en && (rd_a_en || rd_b_en) |->
      (!rd_a_en || rd_a_addr != wr_addr) && (!rd_b_en || rd_b_addr != wr_addr))
    else $error("state RAM read and write collide");

  // A finished generate always presents its word
  assert property (@(posedge clk) disable iff (rst)
    state == mtg_pkg::ST_GEN_OUT && out_free |=> out.valid && state == mtg_pkg::ST_IDLE)
    else $error("generated word not presented");

endmodule

`default_nettype wire
